// ===== sv/imm_pkg.sv =====
// Shared types and codes for the integer matrix multiply unit.
package imm_pkg;

  localparam int DATA_W  = 32;
  localparam int COORD_W = 3;
  localparam int DIM_W   = 4;

  // action codes
  localparam logic [1:0] ACT_LOAD_A  = 2'd0;
  localparam logic [1:0] ACT_LOAD_B  = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  // one A element traveling down the cell chain
  typedef struct packed {
    logic               vld;
    logic               first;
    logic [COORD_W-1:0] k;
    logic [DATA_W-1:0]  a;
  } tok_t;

  // B element write broadcast to all cells
  typedef struct packed {
    logic               we;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [DATA_W-1:0]  data;
  } bwr_t;

endpackage

// ===== sv/imm_if.sv =====
// Channel interfaces: input items, result items and configuration writes.
interface imm_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [2:0]                    row_index;
  logic [2:0]                    col_index;
  logic signed [31:0]            element_value;
  modport source (output valid, action, row_index, col_index, element_value, input ready);
  modport sink   (input valid, action, row_index, col_index, element_value, output ready);
endinterface

interface imm_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [31:0]            product_value;
  logic [2:0]                    out_row;
  logic [2:0]                    out_col;
  logic                          last_element;
  modport source (output valid, product_value, out_row, out_col, last_element, input ready);
  modport sink   (input valid, product_value, out_row, out_col, last_element, output ready);
endinterface

interface imm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    index;
  logic [3:0]                    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/imm_cell.sv =====
// One column cell: holds a column of B, multiplies passing A elements, accumulates.
module imm_cell #(
  parameter int MAX_DIM = 8,
  parameter int COL     = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  imm_pkg::tok_t              tok_in,
  output imm_pkg::tok_t              tok_out,
  input  imm_pkg::bwr_t              bwr,
  input  logic                       capture,
  input  logic                       shift,
  input  logic [imm_pkg::DATA_W-1:0] shift_in,
  output logic [imm_pkg::DATA_W-1:0] shift_out
);
  import imm_pkg::*;

  localparam int KW = $clog2(MAX_DIM);

  logic [DATA_W-1:0] bmem [MAX_DIM];
  tok_t              tok_r;
  logic [DATA_W-1:0] b_r;
  logic [DATA_W-1:0] prod_r;
  logic              pvld_r;
  logic              pfirst_r;
  logic [DATA_W-1:0] acc_r;
  logic [DATA_W-1:0] out_r;

  // write own column of B, read it for the arriving token
  always_ff @(posedge clk) begin
    if (bwr.we && int'(bwr.col) == COL) begin
      bmem[KW'(bwr.row)] <= bwr.data;
    end
    b_r <= bmem[KW'(tok_in.k)];
  end

  // register the token, then hand it on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= '0;
      pvld_r <= 1'b0;
    end else begin
      tok_r  <= tok_in;
      pvld_r <= tok_r.vld;
    end
  end

  // multiply, then accumulate
  always_ff @(posedge clk) begin
    prod_r   <= tok_r.a * b_r;
    pfirst_r <= tok_r.first;
    if (pvld_r) begin
      acc_r <= pfirst_r ? prod_r : acc_r + prod_r;
    end
  end

  // result shift line toward cell zero
  always_ff @(posedge clk) begin
    if (capture) begin
      out_r <= acc_r;
    end else if (shift) begin
      out_r <= shift_in;
    end
  end

  assign tok_out   = tok_r;
  assign shift_out = out_r;

endmodule

// ===== sv/integer_matrix_multiply_unit.sv =====
// Integer matrix multiply unit. Load beats (one per cycle, no result) write an
// element of A into a local memory or of B into the column cells; a compute beat
// forms C = A*B over the configured sizes n x m x p and emits C row-major. Each
// row of C feeds its m A elements into a chain of MAX_DIM column cells, waits
// for the tokens to pass the chain, then shifts p result beats out of the chain.
// The input is not taken while a compute runs.
module integer_matrix_multiply_unit #(
  parameter int MAX_DIM = 8
) (
  input logic      clk,
  input logic      rst_n,
  imm_in_if.sink   in_ch,
  imm_out_if.source out_ch,
  imm_cfg_if.sink  cfg_ch
);
  import imm_pkg::*;

  localparam int LIM   = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam int AAW   = $clog2(MAX_DIM * MAX_DIM);
  localparam int DRAIN = MAX_DIM + 4;
  localparam int DW    = $clog2(DRAIN + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (int'(v) > LIM) return DIM_W'(LIM);
    return v;
  endfunction

  state_t             state_r, state_nxt;
  logic [DIM_W-1:0]   rows_r, inner_r, cols_r;
  logic [DIM_W-1:0]   n_r, m_r, p_r, n_nxt, m_nxt, p_nxt;
  logic [COORD_W-1:0] i_r, j_r, k_r, i_nxt, j_nxt, k_nxt;
  logic [DW-1:0]      cnt_r, cnt_nxt;
  logic [DATA_W-1:0]  amem [MAX_DIM * MAX_DIM];
  logic [DATA_W-1:0]  a_rd_r;
  logic               tvld_r, tfirst_r;
  logic [COORD_W-1:0] tk_r;
  logic               in_acc, out_acc, ld_ok, capture, shift;
  bwr_t               bwr;
  tok_t               tok [MAX_DIM+1];
  logic [DATA_W-1:0]  sh  [MAX_DIM+1];

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= DIM_W'(8);
      inner_r <= DIM_W'(8);
      cols_r  <= DIM_W'(8);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ROWS_A:    rows_r  <= cfg_ch.data;
        REG_INNER_DIM: inner_r <= cfg_ch.data;
        REG_COLS_B:    cols_r  <= cfg_ch.data;
        default:       ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;
  assign ld_ok       = int'(in_ch.row_index) < MAX_DIM && int'(in_ch.col_index) < MAX_DIM;

  // A store: written by loads, read once per issued token
  always_ff @(posedge clk) begin
    if (in_acc && ld_ok && in_ch.action == ACT_LOAD_A) begin
      amem[AAW'(int'(in_ch.row_index) * MAX_DIM + int'(in_ch.col_index))] <=
        in_ch.element_value;
    end
    a_rd_r <= amem[AAW'(int'(i_r) * MAX_DIM + int'(k_r))];
  end

  // B writes go to the cells
  always_comb begin
    bwr.we   = in_acc && ld_ok && in_ch.action == ACT_LOAD_B;
    bwr.row  = in_ch.row_index;
    bwr.col  = in_ch.col_index;
    bwr.data = in_ch.element_value;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; m_nxt = m_r; p_nxt = p_r;
    i_nxt = i_r; j_nxt = j_r; k_nxt = k_r;
    cnt_nxt = cnt_r;
    capture = 1'b0;
    shift   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_ch.action == ACT_COMPUTE) begin
          n_nxt = clamp_dim(rows_r);
          m_nxt = clamp_dim(inner_r);
          p_nxt = clamp_dim(cols_r);
          i_nxt = '0;
          k_nxt = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if ({1'b0, k_r} == m_r - DIM_W'(1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + COORD_W'(1);
        end
      end
      ST_DRAIN: begin
        if (cnt_r == DW'(DRAIN)) begin
          capture   = 1'b1;
          j_nxt     = '0;
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + DW'(1);
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          shift = 1'b1;
          if ({1'b0, j_r} == p_r - DIM_W'(1)) begin
            if ({1'b0, i_r} == n_r - DIM_W'(1)) begin
              state_nxt = ST_IDLE;
            end else begin
              i_nxt     = i_r + COORD_W'(1);
              k_nxt     = '0;
              state_nxt = ST_ISSUE;
            end
          end else begin
            j_nxt = j_r + COORD_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tvld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tvld_r  <= (state_r == ST_ISSUE);
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt; m_r <= m_nxt; p_r <= p_nxt;
    i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt;
    cnt_r    <= cnt_nxt;
    tfirst_r <= (k_r == '0);
    tk_r     <= k_r;
  end

  // cell chain
  always_comb begin
    tok[0].vld   = tvld_r;
    tok[0].first = tfirst_r;
    tok[0].k     = tk_r;
    tok[0].a     = a_rd_r;
  end
  assign sh[MAX_DIM] = '0;

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    imm_cell #(.MAX_DIM(MAX_DIM), .COL(c)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_in   (tok[c]),
      .tok_out  (tok[c+1]),
      .bwr      (bwr),
      .capture  (capture),
      .shift    (shift),
      .shift_in (sh[c+1]),
      .shift_out(sh[c])
    );
  end

  // result beat
  assign out_ch.valid         = (state_r == ST_EMIT);
  assign out_ch.product_value = sh[0];
  assign out_ch.out_row       = i_r;
  assign out_ch.out_col       = j_r;
  assign out_ch.last_element  = ({1'b0, i_r} == n_r - DIM_W'(1)) &&
                                ({1'b0, j_r} == p_r - DIM_W'(1));

endmodule

// ===== sv/imm_checker.sv =====
// Port-level checks for the matrix multiply unit, bound to the top level.
module imm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [31:0] out_value
);
  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value)) else $error("result changed");

  // no input taken while results go out
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready)) else $error("input ready during output");

  // after the last beat the block is free again
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("not idle after last beat");

  // mid-product beats keep the block busy
  a_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !in_ready) else $error("idle mid product");
endmodule

bind integer_matrix_multiply_unit imm_checker u_imm_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_last (out_ch.last_element),
  .out_value(out_ch.product_value)
);

// ===== tb/tb_integer_matrix_multiply_unit.sv =====
// Testbench for the integer matrix multiply unit: loads, computes and checks every product beat.
module tb_integer_matrix_multiply_unit;
  import imm_pkg::*;

  // Expected product elements and the mirror of both matrix stores
  class product_board;
    logic [31:0] a_mem [64];
    logic [31:0] b_mem [64];
    logic [3:0]  rows_reg, inner_reg, cols_reg;
    logic [31:0] exp_val [$];
    logic [2:0]  exp_row [$];
    logic [2:0]  exp_col [$];
    logic        exp_last [$];
    int          mismatches;

    function new();
      foreach (a_mem[i]) begin
        a_mem[i] = '0;
        b_mem[i] = '0;
      end
      rows_reg = 4'd8;
      inner_reg = 4'd8;
      cols_reg = 4'd8;
      mismatches = 0;
    endfunction

    function int eff_dim(logic [3:0] v);
      if (v == 0) return 1;
      if (v > 8) return 8;
      return v;
    endfunction

    // Note one accepted input beat and queue the products it causes
    function void note_input(logic [1:0] act, logic [2:0] r, logic [2:0] c,
                             logic [31:0] v);
      int n, m, p;
      logic [31:0] acc;
      n = eff_dim(rows_reg);
      m = eff_dim(inner_reg);
      p = eff_dim(cols_reg);
      if (act == ACT_LOAD_A) a_mem[r * 8 + c] = v;
      else if (act == ACT_LOAD_B) b_mem[r * 8 + c] = v;
      else if (act == ACT_COMPUTE) begin
        for (int i = 0; i < n; i++) begin
          for (int j = 0; j < p; j++) begin
            acc = '0;
            for (int k = 0; k < m; k++) acc += a_mem[i * 8 + k] * b_mem[k * 8 + j];
            exp_val.push_back(acc);
            exp_row.push_back(i[2:0]);
            exp_col.push_back(j[2:0]);
            exp_last.push_back(i == n - 1 && j == p - 1);
          end
        end
      end
    endfunction

    // Check one product beat against the oldest expectation
    function void check_product(logic [31:0] v, logic [2:0] r, logic [2:0] c, logic l);
      logic [31:0] ev;
      logic [2:0]  er, ec;
      logic        el;
      if (exp_val.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected product beat %h (%0d,%0d)", v, r, c);
        return;
      end
      ev = exp_val.pop_front();
      er = exp_row.pop_front();
      ec = exp_col.pop_front();
      el = exp_last.pop_front();
      if (v !== ev || r !== er || c !== ec || l !== el) begin
        mismatches++;
        if (mismatches <= 10)
          $display("product mismatch: exp %h (%0d,%0d) last %0b, got %h (%0d,%0d) last %0b",
                   ev, er, ec, el, v, r, c, l);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  imm_in_if  in_ch();
  imm_out_if out_ch();
  imm_cfg_if cfg_ch();
  product_board board;
  int in_idle_pct, out_idle_pct;
  longint cycles;
  logic [2:0] arow;
  logic [2:0] acol;

  integer_matrix_multiply_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Sample accepted beats at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      board.note_input(in_ch.action, in_ch.row_index, in_ch.col_index, in_ch.element_value);
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_product(out_ch.product_value, out_ch.out_row, out_ch.out_col,
                          out_ch.last_element);
  end

  // Receiver stalls at random
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("tb_integer_matrix_multiply_unit: done, errors");
      $finish;
    end
  end

  // Drive one beat; valid stays up on return until the next beat or a drain
  task automatic send_beat(logic [1:0] act, logic [2:0] r, logic [2:0] c, logic [31:0] v);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.action <= act;
    in_ch.row_index <= r;
    in_ch.col_index <= c;
    in_ch.element_value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 0;
    while (board.exp_val.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_ROWS_A) board.rows_reg = val;
    else if (idx == REG_INNER_DIM) board.inner_reg = val;
    else board.cols_reg = val;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(20) - 10;
      default: return $urandom;
    endcase
  endfunction

  // Fill every store entry so no compute reads an unwritten element
  task automatic fill_all();
    for (int i = 0; i < 64; i++) send_beat(ACT_LOAD_A, 3'(i / 8), 3'(i % 8), rand_elem());
    for (int i = 0; i < 64; i++) send_beat(ACT_LOAD_B, 3'(i / 8), 3'(i % 8), rand_elem());
  endtask

  task automatic set_sizes(logic [3:0] n, logic [3:0] m, logic [3:0] p);
    wait_drained();
    write_reg(REG_ROWS_A, n);
    write_reg(REG_INNER_DIM, m);
    write_reg(REG_COLS_B, p);
    cfg_ch.valid <= 0;
  endtask

  initial begin
    board = new();
    cycles = 0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    in_ch.valid = 0;
    in_ch.action = ACT_LOAD_A;
    in_ch.row_index = 0;
    in_ch.col_index = 0;
    in_ch.element_value = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = REG_ROWS_A;
    cfg_ch.data = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: full stores, default 8x8x8, extremes of the sizes
    fill_all();
    send_beat(ACT_COMPUTE, 3'd7, 3'd7, 32'hffff_ffff);
    send_beat(2'd3, 3'd0, 3'd0, 32'h1234_5678);
    set_sizes(4'd1, 4'd1, 4'd1);
    send_beat(ACT_COMPUTE, '0, '0, '0);
    set_sizes(4'd0, 4'd15, 4'd9);
    send_beat(ACT_COMPUTE, '0, '0, '0);
    set_sizes(4'd8, 4'd1, 4'd2);
    send_beat(ACT_LOAD_A, 3'd7, 3'd0, 32'h8000_0000);
    send_beat(ACT_LOAD_B, 3'd0, 3'd1, 32'h8000_0000);
    send_beat(ACT_COMPUTE, '0, '0, '0);

    // Random: mostly loads followed by a compute, three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 62 : 0;
      out_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 10 : 0;
      for (int s = 0; s < 6; s++) begin
        set_sizes(4'($urandom_range(15)), 4'($urandom_range(15)), 4'($urandom_range(15)));
        if (s == 3) wait_drained();
        for (int t = 0; t < 20; t++) begin
          case ($urandom_range(19))
            0: send_beat(2'd3, 3'($urandom), 3'($urandom), $urandom);
            1: send_beat(ACT_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
            default: begin
              arow = 3'($urandom);
              acol = 3'($urandom);
              send_beat(2'($urandom_range(1)), arow, acol, rand_elem());
            end
          endcase
        end
        send_beat(ACT_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
      end
    end

    wait_drained();
    repeat (100) @(negedge clk);
    if (board.mismatches == 0 && board.exp_val.size() == 0) begin
      $display("tb_integer_matrix_multiply_unit: done, clean");
    end else begin
      $display("tb_integer_matrix_multiply_unit: done, errors");
    end
    $finish;
  end
endmodule
